// ----- hw/rtl/sat_pkg.sv -----
// Shared types and constants for the seen-address table with aging.
`default_nettype none

package sat_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int ADDR_W        = 48;
    localparam int TIME_W        = 32;
    localparam int RSSI_W        = 8;
    localparam int COUNT_W       = 7;
    localparam int CFG_DATA_W    = 32;

    localparam logic [COUNT_W-1:0]    COUNT_MAX       = 7'd127;
    localparam logic [RSSI_W-1:0]     RSSI_THR_RESET  = 8'hBA;
    localparam logic [TIME_W-1:0]     MAX_AGE_RESET   = 32'd60000;

    typedef enum logic {
        CFG_RSSI_THRESHOLD = 1'b0,
        CFG_MAX_AGE_MS     = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        OUT_IGNORED   = 2'd0,
        OUT_REFRESHED = 2'd1,
        OUT_INSERTED  = 2'd2,
        OUT_DROPPED   = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] seen;
    } t_entry;

    typedef struct packed {
        logic              shift;
        logic [ADDR_W-1:0] key;
    } t_chain_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/seen_address_table_with_aging_top.sv -----
// Top level of the seen-address table with aging: entry chain and sequencer.
`default_nettype none

// Keeps up to TABLE_DEPTH source addresses with their last-seen times. Entries sit
// in a ring of cells; for each frame above the signal threshold the ring rotates
// once through a single head stage, which refreshes the matching entry or, for a
// new address, purges aged entries, counts the rest and fills the first free slot.
// A frame at or below the threshold goes from lookup straight to its result; any
// other frame waits for the full rotation of the ring. One frame is handled at a
// time; a finished result waits in the output register while the next frame is
// taken. Entry contents need no clearing after reset, so frames are taken at once.
module seen_address_table_with_aging_top #(
    parameter int TABLE_DEPTH = sat_pkg::DEFAULT_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_index,
    input  wire [sat_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire [sat_pkg::ADDR_W-1:0]        i_source_mac,
    input  wire signed [sat_pkg::RSSI_W-1:0] i_rssi,
    input  wire [sat_pkg::TIME_W-1:0]        i_now_ms,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [1:0]                       o_outcome,
    output logic [sat_pkg::COUNT_W-1:0]      o_device_count
);
    import sat_pkg::*;

    t_entry             w_entry [TABLE_DEPTH];
    t_entry             w_head;
    t_chain_ctl         w_ctl;
    logic [TABLE_DEPTH-1:0] w_match;

    sat_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_source_mac   (i_source_mac),
        .i_rssi         (i_rssi),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_outcome      (o_outcome),
        .o_device_count (o_device_count),
        .i_any_match    (|w_match),
        .i_tail         (w_entry[TABLE_DEPTH-1]),
        .o_head         (w_head),
        .o_ctl          (w_ctl)
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            sat_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_entry (w_head),
                .o_entry (w_entry[g]),
                .o_match (w_match[g])
            );
        end else begin : g_rest
            sat_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_entry (w_entry[g-1]),
                .o_entry (w_entry[g]),
                .o_match (w_match[g])
            );
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sat_cell.sv -----
// One table entry of the rotating chain, with its own address comparator.
`default_nettype none

module sat_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire sat_pkg::t_chain_ctl  i_ctl,
    input  wire sat_pkg::t_entry      i_entry,
    output sat_pkg::t_entry           o_entry,
    output logic                      o_match
);
    import sat_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [TIME_W-1:0] r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_addr <= i_entry.addr;
            r_seen <= i_entry.seen;
        end
    end

    assign o_entry.valid = r_valid;
    assign o_entry.addr  = r_addr;
    assign o_entry.seen  = r_seen;
    assign o_match       = r_valid && (r_addr == i_ctl.key);

endmodule

`default_nettype wire

// ----- hw/rtl/sat_ctrl.sv -----
// Sequencer, configuration registers and head update stage of the entry chain.
`default_nettype none

module sat_ctrl #(
    parameter int TABLE_DEPTH = sat_pkg::DEFAULT_DEPTH
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire                            i_cfg_index,
    input  wire [sat_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire [sat_pkg::ADDR_W-1:0]      i_source_mac,
    input  wire signed [sat_pkg::RSSI_W-1:0] i_rssi,
    input  wire [sat_pkg::TIME_W-1:0]      i_now_ms,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [1:0]                     o_outcome,
    output logic [sat_pkg::COUNT_W-1:0]    o_device_count,
    input  wire                            i_any_match,
    input  wire sat_pkg::t_entry           i_tail,
    output sat_pkg::t_entry                o_head,
    output sat_pkg::t_chain_ctl            o_ctl
);
    import sat_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_key, n_key;
    logic [TIME_W-1:0]  r_now, n_now;
    logic               r_strong, n_strong;
    logic               r_hit, n_hit;
    logic               r_inserted, n_inserted;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [COUNT_W-1:0] r_held, n_held;
    logic               r_out_valid, n_out_valid;
    t_outcome           r_outcome, n_outcome;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [RSSI_W-1:0]  r_thr;
    logic [TIME_W-1:0]  r_max_age;

    logic [TIME_W-1:0]  w_age;
    logic               w_expired;
    logic               w_take_slot;
    logic [COUNT_W-1:0] w_sat_n;
    t_entry             w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= RSSI_THR_RESET;
            r_max_age <= MAX_AGE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_RSSI_THRESHOLD: r_thr     <= i_cfg_data[RSSI_W-1:0];
                CFG_MAX_AGE_MS:     r_max_age <= i_cfg_data[TIME_W-1:0];
                default:            r_thr     <= r_thr;
            endcase
        end
    end

    // Head stage: refresh on a hit, otherwise purge, count and fill the first free slot.
    always_comb begin
        w_age       = r_now - i_tail.seen;
        w_expired   = w_age > r_max_age;
        w_take_slot = 1'b0;
        w_head      = i_tail;
        if (r_hit) begin
            if (i_tail.valid && (i_tail.addr == r_key)) begin
                w_head.seen = r_now;
            end
        end else begin
            w_head.valid = i_tail.valid && !w_expired;
            if (!w_head.valid && !r_inserted) begin
                w_take_slot  = 1'b1;
                w_head.valid = 1'b1;
                w_head.addr  = r_key;
                w_head.seen  = r_now;
            end
        end
    end

    assign w_sat_n = (32'(r_n) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_now      <= n_now;
        r_strong   <= n_strong;
        r_hit      <= n_hit;
        r_inserted <= n_inserted;
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_outcome  <= n_outcome;
        r_count    <= n_count;
    end

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_now       = r_now;
        n_strong    = r_strong;
        n_hit       = r_hit;
        n_inserted  = r_inserted;
        n_idx       = r_idx;
        n_n         = r_n;
        n_held      = r_held;
        n_out_valid = r_out_valid && !i_out_ready;
        n_outcome   = r_outcome;
        n_count     = r_count;
        o_in_ready  = 1'b0;
        o_ctl.shift = 1'b0;
        o_ctl.key   = r_key;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_key    = i_source_mac;
                    n_now    = i_now_ms;
                    n_strong = i_rssi > $signed(r_thr);
                    n_state  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_hit      = i_any_match;
                n_inserted = 1'b0;
                n_idx      = '0;
                n_n        = '0;
                n_state    = r_strong ? ST_WALK : ST_FINISH;
            end
            ST_WALK: begin
                o_ctl.shift = 1'b1;
                n_idx       = r_idx + 1'b1;
                n_inserted  = r_inserted || w_take_slot;
                n_n         = r_n + CNT_W'(w_head.valid);
                if (r_idx == LAST_IDX) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (!r_strong) begin
                        n_outcome = OUT_IGNORED;
                        n_count   = r_held;
                    end else if (r_hit) begin
                        n_outcome = OUT_REFRESHED;
                        n_count   = r_held;
                    end else begin
                        n_outcome = r_inserted ? OUT_INSERTED : OUT_DROPPED;
                        n_held    = w_sat_n;
                        n_count   = w_sat_n;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_head         = w_head;
    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_device_count = r_count;

    a_no_insert_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_hit) |-> !w_take_slot)
        else $error("slot filled during a refresh walk");

    a_walk_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_idx != LAST_IDX) |=>
            (r_state == ST_WALK && r_idx == $past(r_idx) + 1'b1))
        else $error("walk left early or skipped an entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> (32'(r_n) <= 32'(TABLE_DEPTH)))
        else $error("valid entry count exceeds table depth");

    a_single_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_inserted) |-> !w_take_slot)
        else $error("second slot filled in one walk");

endmodule

`default_nettype wire
